FILE: rtl/rcc_pkg.sv
// Package for the radix conversion unit with overflow checking.
// Holds the shared widths, character and status codes, register indexes and digit helpers.
// No dependencies; used by radix_conversion_checked_unit and rcc_checker.
package rcc_pkg;

	localparam int DEFAULT_VALUE_BITS = 32;
	localparam int RADIX_W            = 6;
	localparam int CHAR_W             = 8;
	localparam int STATUS_W           = 2;
	localparam int CFG_IDX_W          = 2;

	localparam logic [RADIX_W-1:0] RADIX_MIN   = 6'd2;
	localparam logic [RADIX_W-1:0] RADIX_LIMIT = 6'd37;
	localparam logic [RADIX_W-1:0] RADIX_RESET = 6'd10;

	localparam logic [CFG_IDX_W-1:0] REG_SRC_RADIX = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_DST_RADIX = 2'd1;

	localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
	localparam logic [STATUS_W-1:0] STATUS_VALUE = 2'd1;
	localparam logic [STATUS_W-1:0] STATUS_RADIX = 2'd2;

	localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2D;
	localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;
	localparam logic [CHAR_W-1:0] CHAR_NINE  = 8'h39;
	localparam logic [CHAR_W-1:0] CHAR_A     = 8'h41;
	localparam logic [CHAR_W-1:0] CHAR_Z     = 8'h5A;
	localparam logic [CHAR_W-1:0] CHAR_NUL   = 8'h00;
	localparam logic [CHAR_W-1:0] DEC_TEN    = 8'd10;

	function automatic logic radix_ok(input logic [RADIX_W-1:0] r);
		return (r >= RADIX_MIN) && (r < RADIX_LIMIT);
	endfunction

	function automatic logic [CHAR_W-1:0] digit_to_char(input logic [RADIX_W-1:0] d);
		logic [CHAR_W-1:0] dw;
		dw = CHAR_W'(d);
		return (dw > 8'd9) ? (dw - DEC_TEN + CHAR_A) : (dw + CHAR_ZERO);
	endfunction

endpackage

FILE: rtl/radix_conversion_checked_unit.sv
// Radix conversion unit: signed text number in one radix to text in another radix.
// Iterative datapath with a checked multiply-add and a one-bit-per-cycle restoring divider.
// Depends on rcc_pkg.
//
// Channel  | Direction | Payload                      | Handshake
// ---------+-----------+------------------------------+-----------------------------
// in       | to unit   | in_char, in_last             | in_valid / in_ready
// out      | from unit | out_char, status, out_last   | out_valid / out_ready
// cfg      | to unit   | cfg_index, cfg_data          | cfg_wr_en, no back-pressure
//
// A character that is not last passes acceptance, which registers the product of the
// accumulator and the source radix, then a state of add, range check and update.
// A last character then runs the divider once per output digit, followed per digit result by
// memory read, output load and transaction, after a sign result if the value is below zero.
// Reset is asynchronous and active low; it restores both radix registers to ten.
// After a last character in_ready stays low until its closing result is taken; a stall holds it.
module radix_conversion_checked_unit #(
	parameter int VALUE_BITS = rcc_pkg::DEFAULT_VALUE_BITS
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_wr_en,
	input  logic [rcc_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [rcc_pkg::RADIX_W-1:0]   cfg_data,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [rcc_pkg::CHAR_W-1:0]    in_char,
	input  logic                          in_last,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [rcc_pkg::CHAR_W-1:0]    out_char,
	output logic [rcc_pkg::STATUS_W-1:0]  status,
	output logic                          out_last
);

	localparam int RW = rcc_pkg::RADIX_W;
	localparam int PW = VALUE_BITS + RW;
	localparam int IW = $clog2(VALUE_BITS);
	localparam int CW = IW + 1;

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_ADD  = 3'd1;
	localparam logic [2:0] S_DIV  = 3'd2;
	localparam logic [2:0] S_RD   = 3'd3;
	localparam logic [2:0] S_LOAD = 3'd4;
	localparam logic [2:0] S_WAIT = 3'd5;

	logic [2:0]                   state_q;
	logic [RW-1:0]                src_radix_q, dst_radix_q;
	logic [VALUE_BITS-1:0]        acc_q;
	logic                         neg_q, first_q, err_q;
	logic [rcc_pkg::CHAR_W-1:0]   ch_q;
	logic                         last_q;
	logic [PW-1:0]                prod_q;
	logic [VALUE_BITS-1:0]        div_q;
	logic [RW-1:0]                rem_q;
	logic [IW-1:0]                bit_cnt_q;
	logic [CW-1:0]                n_q;
	logic                         sign_q;
	logic [RW-1:0]                rd_q;
	logic                         out_valid_q, out_last_q;
	logic [rcc_pkg::CHAR_W-1:0]   out_char_q;
	logic [rcc_pkg::STATUS_W-1:0] status_q;
	logic [RW-1:0]                dig_mem [VALUE_BITS];

	// Accumulate step
	logic                  is_num, is_alpha, src_ok, dst_ok;
	logic [RW-1:0]         digit;
	logic [PW:0]           sum, half_w, lim;
	logic [VALUE_BITS-1:0] acc_n;
	logic                  neg_n, err_n;

	// Divider step
	logic [RW:0]           trial;
	logic                  ge;
	logic [RW-1:0]         rem_nx;
	logic [VALUE_BITS-1:0] quo_nx;
	logic                  div_done;
	logic [CW-1:0]         n_inc, n_dec;

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;
	assign out_char  = out_char_q;
	assign status    = status_q;
	assign out_last  = out_last_q;

	always_comb begin
		is_num   = (ch_q inside {[rcc_pkg::CHAR_ZERO:rcc_pkg::CHAR_NINE]});
		is_alpha = (ch_q inside {[rcc_pkg::CHAR_A:rcc_pkg::CHAR_Z]});
		digit    = is_num ? RW'(ch_q - rcc_pkg::CHAR_ZERO)
		                  : RW'(ch_q - rcc_pkg::CHAR_A + rcc_pkg::DEC_TEN);
		src_ok   = rcc_pkg::radix_ok(src_radix_q);
		dst_ok   = rcc_pkg::radix_ok(dst_radix_q);
		sum      = {1'b0, prod_q} + (PW+1)'(digit);
		half_w   = '0;
		half_w[VALUE_BITS-1] = 1'b1;
		// A negative value may reach one more than the largest positive one.
		lim      = neg_q ? half_w : (half_w - (PW+1)'(1));
		acc_n    = acc_q;
		neg_n    = neg_q;
		err_n    = err_q;
		if (!err_q) begin
			if (first_q && (ch_q == rcc_pkg::CHAR_MINUS)) begin
				neg_n = 1'b1;
			end else if (!(is_num || is_alpha) || !src_ok || (digit >= src_radix_q)) begin
				err_n = 1'b1;
			end else if (sum > lim) begin
				err_n = 1'b1;
			end else begin
				acc_n = sum[VALUE_BITS-1:0];
			end
		end
	end

	always_comb begin
		trial    = {rem_q, div_q[VALUE_BITS-1]};
		ge       = (trial >= {1'b0, dst_radix_q});
		rem_nx   = ge ? RW'(trial - {1'b0, dst_radix_q}) : trial[RW-1:0];
		quo_nx   = {div_q[VALUE_BITS-2:0], ge};
		div_done = (bit_cnt_q == IW'(VALUE_BITS - 1));
		n_inc    = n_q + CW'(1);
		n_dec    = n_q - CW'(1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			src_radix_q <= rcc_pkg::RADIX_RESET;
			dst_radix_q <= rcc_pkg::RADIX_RESET;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				rcc_pkg::REG_SRC_RADIX: src_radix_q <= cfg_data;
				rcc_pkg::REG_DST_RADIX: dst_radix_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Digit store: remainders in order of significance, read back from the top.
	always_ff @(posedge clk) begin
		if (state_q == S_DIV && div_done) begin
			dig_mem[n_q[IW-1:0]] <= rem_nx;
		end
		if (state_q == S_RD) begin
			rd_q <= dig_mem[n_dec[IW-1:0]];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			acc_q       <= '0;
			neg_q       <= 1'b0;
			first_q     <= 1'b1;
			err_q       <= 1'b0;
			ch_q        <= rcc_pkg::CHAR_NUL;
			last_q      <= 1'b0;
			prod_q      <= '0;
			div_q       <= '0;
			rem_q       <= '0;
			n_q         <= '0;
			bit_cnt_q   <= '0;
			sign_q      <= 1'b0;
			out_valid_q <= 1'b0;
			out_char_q  <= rcc_pkg::CHAR_NUL;
			status_q    <= rcc_pkg::STATUS_OK;
			out_last_q  <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						ch_q    <= in_char;
						last_q  <= in_last;
						prod_q  <= PW'(acc_q) * PW'(src_radix_q);
						state_q <= S_ADD;
					end
				end
				S_ADD: begin
					if (last_q) begin
						acc_q   <= '0;
						neg_q   <= 1'b0;
						first_q <= 1'b1;
						err_q   <= 1'b0;
						if (!src_ok || !dst_ok) begin
							out_valid_q <= 1'b1;
							out_char_q  <= rcc_pkg::CHAR_NUL;
							status_q    <= rcc_pkg::STATUS_RADIX;
							out_last_q  <= 1'b1;
							state_q     <= S_WAIT;
						end else if (err_n) begin
							out_valid_q <= 1'b1;
							out_char_q  <= rcc_pkg::CHAR_NUL;
							status_q    <= rcc_pkg::STATUS_VALUE;
							out_last_q  <= 1'b1;
							state_q     <= S_WAIT;
						end else begin
							div_q     <= acc_n;
							sign_q    <= neg_n && (acc_n != '0);
							rem_q     <= '0;
							bit_cnt_q <= '0;
							n_q       <= '0;
							state_q   <= S_DIV;
						end
					end else begin
						acc_q   <= acc_n;
						neg_q   <= neg_n;
						err_q   <= err_n;
						first_q <= 1'b0;
						state_q <= S_IDLE;
					end
				end
				S_DIV: begin
					div_q <= quo_nx;
					if (div_done) begin
						rem_q     <= '0;
						bit_cnt_q <= '0;
						n_q       <= n_inc;
						if ((quo_nx == '0) || (n_inc == CW'(VALUE_BITS))) begin
							if (sign_q) begin
								out_valid_q <= 1'b1;
								out_char_q  <= rcc_pkg::CHAR_MINUS;
								status_q    <= rcc_pkg::STATUS_OK;
								out_last_q  <= 1'b0;
								state_q     <= S_WAIT;
							end else begin
								state_q <= S_RD;
							end
						end
					end else begin
						rem_q     <= rem_nx;
						bit_cnt_q <= bit_cnt_q + IW'(1);
					end
				end
				S_RD: begin
					n_q     <= n_dec;
					state_q <= S_LOAD;
				end
				S_LOAD: begin
					out_valid_q <= 1'b1;
					out_char_q  <= rcc_pkg::digit_to_char(rd_q);
					status_q    <= rcc_pkg::STATUS_OK;
					out_last_q  <= (n_q == '0);
					state_q     <= S_WAIT;
				end
				S_WAIT: begin
					if (out_ready) begin
						out_valid_q <= 1'b0;
						state_q     <= out_last_q ? S_IDLE : S_RD;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

FILE: rtl/rcc_checker.sv
// Port-level checker for radix_conversion_checked_unit, attached by the bind below.
// Watches the input and output channels over time; depends on rcc_pkg.
module rcc_port_checks (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          in_valid,
	input logic                          in_ready,
	input logic                          out_valid,
	input logic                          out_ready,
	input logic [rcc_pkg::CHAR_W-1:0]    out_char,
	input logic [rcc_pkg::STATUS_W-1:0]  status,
	input logic                          out_last
);

	// The unit never takes a new transaction while a result is on offer.
	assert property (@(posedge clk) disable iff (!arst_n) !(in_ready && out_valid))
		else $error("input accepted while a result is pending");

	// An error result is a single NUL character closing the value.
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && (status != rcc_pkg::STATUS_OK))
		|-> (out_last && (out_char == rcc_pkg::CHAR_NUL)))
		else $error("error result is not a lone closing transaction");

	// A sign is always followed by at least one digit.
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && (status == rcc_pkg::STATUS_OK) && (out_char == rcc_pkg::CHAR_MINUS))
		|-> !out_last)
		else $error("sign emitted as the final character");

	// A stalled result holds its payload.
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> (out_valid && $stable(out_char) && $stable(status)
		&& $stable(out_last)))
		else $error("stalled result changed");

	// Once the closing result is taken the unit is ready again.
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_ready && out_last) |=> in_ready)
		else $error("unit not ready after the closing result");

endmodule

bind radix_conversion_checked_unit rcc_port_checks u_rcc_port_checks (.*);

FILE: sim/rcc_checker.sv
// Checker for the radix conversion unit: follows the configuration writes and the input
// transactions, predicts the converted characters and compares every output transaction.
// Depends on rcc_pkg; instantiated beside the unit by radix_conversion_checked_unit_tb.
`timescale 1ns / 1ps
module rcc_checker #(
	parameter int VALUE_BITS = rcc_pkg::DEFAULT_VALUE_BITS
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_wr_en,
	input  logic [rcc_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [rcc_pkg::RADIX_W-1:0]   cfg_data,
	input  logic                          in_valid,
	input  logic                          in_ready,
	input  logic [rcc_pkg::CHAR_W-1:0]    in_char,
	input  logic                          in_last,
	input  logic                          out_valid,
	input  logic                          out_ready,
	input  logic [rcc_pkg::CHAR_W-1:0]    out_char,
	input  logic [rcc_pkg::STATUS_W-1:0]  status,
	input  logic                          out_last,
	output int                            mismatch_count,
	output int                            outstanding
);
	import rcc_pkg::*;

	typedef struct packed {
		logic [CHAR_W-1:0]   ch;
		logic [STATUS_W-1:0] st;
		logic                last;
	} conv_char_t;

	conv_char_t         expected_chars[$];
	logic [RADIX_W-1:0] src_radix;
	logic [RADIX_W-1:0] dst_radix;
	logic [63:0]        magnitude;
	logic               negative;
	logic               first_char;
	logic               value_bad;
	int                 errors;

	function automatic logic in_radix_range(input logic [RADIX_W-1:0] r);
		return r > 1 && r < RADIX_LIMIT;
	endfunction

	function automatic int digit_value(input logic [CHAR_W-1:0] c);
		if (c >= CHAR_ZERO && c <= CHAR_NINE)
			return int'(c - CHAR_ZERO);
		if (c >= CHAR_A && c <= CHAR_Z)
			return int'(c - CHAR_A) + 10;
		return -1;
	endfunction

	function automatic logic [CHAR_W-1:0] digit_glyph(input int d);
		return (d > 9) ? CHAR_W'(CHAR_A + d - 10) : CHAR_W'(CHAR_ZERO + d);
	endfunction

	task automatic clear_value();
		magnitude  = '0;
		negative   = 1'b0;
		first_char = 1'b1;
		value_bad  = 1'b0;
	endtask

	task automatic absorb_char(input logic [CHAR_W-1:0] c);
		logic        was_first;
		int          d;
		logic [63:0] limit;
		was_first  = first_char;
		first_char = 1'b0;
		if (value_bad)
			return;
		if (was_first && c == CHAR_MINUS) begin
			negative = 1'b1;
			return;
		end
		d = digit_value(c);
		if (d < 0 || !in_radix_range(src_radix) || d >= int'(src_radix)) begin
			value_bad = 1'b1;
			return;
		end
		// A negative value may reach one step further than a positive one.
		limit = (64'd1 << (VALUE_BITS - 1)) - (negative ? 64'd0 : 64'd1);
		if (magnitude > (limit - 64'(d)) / 64'(src_radix)) begin
			value_bad = 1'b1;
			return;
		end
		magnitude = magnitude * 64'(src_radix) + 64'(d);
	endtask

	task automatic predict_conversion();
		int          digits[$];
		logic [63:0] rest;
		if (!in_radix_range(src_radix) || !in_radix_range(dst_radix)) begin
			expected_chars.push_back('{CHAR_NUL, STATUS_RADIX, 1'b1});
		end else if (value_bad) begin
			expected_chars.push_back('{CHAR_NUL, STATUS_VALUE, 1'b1});
		end else begin
			rest = magnitude;
			do begin
				digits.push_back(int'(rest % 64'(dst_radix)));
				rest = rest / 64'(dst_radix);
			end while (rest != 0 && digits.size() < VALUE_BITS);
			if (negative && magnitude != 0)
				expected_chars.push_back('{CHAR_MINUS, STATUS_OK, 1'b0});
			for (int i = digits.size() - 1; i >= 0; i--)
				expected_chars.push_back('{digit_glyph(digits[i]), STATUS_OK, i == 0});
		end
		clear_value();
	endtask

	task automatic check_output();
		conv_char_t want;
		if (expected_chars.size() == 0) begin
			$display("%0t: unexpected output, expected none, got char %h status %0d last %0b",
				$time, out_char, status, out_last);
			errors++;
			return;
		end
		want = expected_chars.pop_front();
		if (out_char !== want.ch) begin
			$display("%0t: out_char expected %h, got %h", $time, want.ch, out_char);
			errors++;
		end
		if (status !== want.st) begin
			$display("%0t: status expected %0d, got %0d", $time, want.st, status);
			errors++;
		end
		if (out_last !== want.last) begin
			$display("%0t: out_last expected %0b, got %0b", $time, want.last, out_last);
			errors++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			expected_chars.delete();
			src_radix = RADIX_RESET;
			dst_radix = RADIX_RESET;
			clear_value();
			errors = 0;
			mismatch_count <= 0;
			outstanding <= 0;
		end else begin
			if (out_valid && out_ready)
				check_output();
			if (cfg_wr_en) begin
				case (cfg_index)
					REG_SRC_RADIX: src_radix = cfg_data;
					REG_DST_RADIX: dst_radix = cfg_data;
					default: ;
				endcase
			end
			if (in_valid && in_ready) begin
				absorb_char(in_char);
				if (in_last)
					predict_conversion();
			end
			mismatch_count <= errors;
			outstanding <= expected_chars.size();
		end
	end

endmodule

FILE: sim/radix_conversion_checked_unit_tb.sv
// Testbench top for radix_conversion_checked_unit: drives the configuration and character
// stream with random idling and back-pressure, and reports the verdict of rcc_checker.
// Depends on rcc_pkg, radix_conversion_checked_unit and rcc_checker.
`timescale 1ns / 1ps
module radix_conversion_checked_unit_tb;
	import rcc_pkg::*;

	localparam int VALUE_BITS = DEFAULT_VALUE_BITS;
	localparam string DIGIT_SET = "0123456789ABCDEFGHIJKLMNOPQRSTUVWXYZ";
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 2'd3;
	localparam int HOLD_CYCLES = 3000;
	localparam int PHASE_CHARS = 75;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 cfg_wr_en = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [RADIX_W-1:0]   cfg_data = '0;
	logic                 in_valid = 1'b0;
	logic                 in_ready;
	logic [CHAR_W-1:0]    in_char = '0;
	logic                 in_last = 1'b0;
	logic                 out_valid;
	logic                 out_ready = 1'b0;
	logic [CHAR_W-1:0]    out_char;
	logic [STATUS_W-1:0]  status;
	logic                 out_last;

	int   mismatch_count;
	int   outstanding;
	int   send_idle_pct = 37;
	int   rcv_idle_pct = 73;
	logic hold_toggle = 1'b0;
	logic hold_seen = 1'b0;
	int   hold_left = 0;
	int   chars_sent = 0;
	int   cur_src = 10;
	logic [CHAR_W-1:0] char_q[$];

	always #4 clk = ~clk;

	radix_conversion_checked_unit #(.VALUE_BITS(VALUE_BITS)) u_dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_ready(in_ready), .in_char(in_char), .in_last(in_last),
		.out_valid(out_valid), .out_ready(out_ready), .out_char(out_char),
		.status(status), .out_last(out_last)
	);

	rcc_checker #(.VALUE_BITS(VALUE_BITS)) u_check (
		.clk(clk), .arst_n(arst_n),
		.cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_ready(in_ready), .in_char(in_char), .in_last(in_last),
		.out_valid(out_valid), .out_ready(out_ready), .out_char(out_char),
		.status(status), .out_last(out_last),
		.mismatch_count(mismatch_count), .outstanding(outstanding)
	);

	// The receiver: random stalls, or a long hold whenever the stimulus flips hold_toggle.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
			hold_seen <= 1'b0;
			hold_left <= 0;
		end else if (hold_toggle != hold_seen) begin
			hold_seen <= hold_toggle;
			hold_left <= HOLD_CYCLES;
			out_ready <= 1'b0;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
			out_ready <= 1'b0;
		end else begin
			out_ready <= ($urandom_range(99) >= rcv_idle_pct);
		end
	end

	task automatic send_char(input logic [CHAR_W-1:0] c, input logic last);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_char <= c;
		in_last <= last;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		chars_sent++;
	endtask

	task automatic send_queued();
		foreach (char_q[i])
			send_char(char_q[i], i == char_q.size() - 1);
	endtask

	task automatic send_text(input string s);
		char_q.delete();
		for (int i = 0; i < s.len(); i++)
			char_q.push_back(s[i]);
		send_queued();
	endtask

	// Called straight after an accepted transaction; drops valid so the item is not taken twice.
	task automatic wait_idle();
		in_valid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic program_radices(input logic [RADIX_W-1:0] src, input logic [RADIX_W-1:0] dst);
		cfg_wr_en <= 1'b1;
		cfg_index <= REG_SRC_RADIX;
		cfg_data <= src;
		@(posedge clk);
		cfg_index <= REG_DST_RADIX;
		cfg_data <= dst;
		@(posedge clk);
		// Writes to the unused indexes must leave both radices alone.
		cfg_index <= $urandom_range(1) ? REG_SPARE_HI : REG_SPARE_LO;
		cfg_data <= RADIX_W'($urandom);
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		cur_src = int'(src);
	endtask

	function automatic logic [RADIX_W-1:0] pick_radix();
		case ($urandom_range(9))
			0: return 6'd2;
			1: return 6'd36;
			2: case ($urandom_range(4))
				0: return 6'd0;
				1: return 6'd1;
				2: return 6'd37;
				3: return 6'd63;
				default: return RADIX_W'($urandom_range(37, 63));
			endcase
			default: return RADIX_W'($urandom_range(2, 36));
		endcase
	endfunction

	task automatic push_magnitude(input logic [63:0] mag, input int radix, input int lead);
		logic [CHAR_W-1:0] digs[$];
		logic [63:0]       rest;
		rest = mag;
		do begin
			digs.push_front(DIGIT_SET[int'(rest % 64'(radix))]);
			rest = rest / 64'(radix);
		end while (rest != 0);
		repeat (lead) char_q.push_back(CHAR_ZERO);
		foreach (digs[i])
			char_q.push_back(digs[i]);
	endtask

	// Mostly well-formed numbers in the current source radix, the rest arbitrary bytes.
	task automatic queue_random_value();
		logic [63:0] mag;
		int          radix;
		char_q.delete();
		radix = (cur_src > 1 && cur_src < 37) ? cur_src : 10;
		if ($urandom_range(99) < 80) begin
			if ($urandom_range(1))
				char_q.push_back(CHAR_MINUS);
			case ($urandom_range(9))
				0, 1, 2, 3: mag = 64'($urandom_range(40));
				4, 5: mag = 64'($urandom >> $urandom_range(31));
				6: mag = 64'h7FFF_FFFF - 64'($urandom_range(3));
				7: mag = 64'h7FFF_FFFF + 64'($urandom_range(2));
				8: mag = {$urandom, $urandom} >> (24 + $urandom_range(16));
				default: mag = '0;
			endcase
			push_magnitude(mag, radix, ($urandom_range(3) == 0) ? $urandom_range(1, 2) : 0);
		end else begin
			repeat ($urandom_range(1, 5)) begin
				case ($urandom_range(3))
					1: char_q.push_back(CHAR_MINUS);
					2: char_q.push_back(DIGIT_SET[$urandom_range(35)]);
					default: char_q.push_back(CHAR_W'($urandom_range(255)));
				endcase
			end
		end
	endtask

	initial begin
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Decimal at reset: zero, sign alone, minus zero, bad digits and a misplaced sign.
		send_text("0");
		send_text("-");
		send_text("-0");
		send_text("A");
		send_text("#5");
		send_text("1-");
		// The most negative value in binary gives the longest answer; one more overflows.
		wait_idle();
		program_radices(6'd36, 6'd2);
		send_text("-ZIK0ZK");
		send_text("ZIK0ZK");
		wait_idle();
		program_radices(6'd35, 6'd36);
		send_text("Z");
		wait_idle();
		program_radices(6'd1, 6'd10);
		send_text("1");
		wait_idle();
		program_radices(6'd10, 6'd63);
		send_text("5");
		wait_idle();
		program_radices(6'd37, 6'd0);
		send_text("7");

		for (int phase = 0; phase < 3; phase++) begin
			int target;
			wait_idle();
			case (phase)
				0: begin
					send_idle_pct = 37;
					rcv_idle_pct <= 73;
				end
				1: begin
					send_idle_pct = 73;
					rcv_idle_pct <= 37;
				end
				default: begin
					send_idle_pct = 0;
					rcv_idle_pct <= 0;
				end
			endcase
			program_radices(pick_radix(), pick_radix());
			if (phase == 2) begin
				// A long output hold while the sender keeps offering characters.
				program_radices(6'd10, 6'd2);
				hold_toggle <= ~hold_toggle;
				send_text("123456789");
				send_text("-42");
			end
			target = chars_sent + PHASE_CHARS;
			while (chars_sent < target) begin
				if ($urandom_range(7) == 0) begin
					wait_idle();
					program_radices(pick_radix(), pick_radix());
				end
				queue_random_value();
				send_queued();
			end
		end

		wait_idle();
		repeat (50) @(posedge clk);
		if (mismatch_count == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

	initial begin
		#(20_000_000);
		$display("RESULT: ERROR");
		$finish;
	end

endmodule
